// File: sv/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// shared types, opcodes, error codes and sizing defaults of the stack machine
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int STACK_DEPTH_DEF  = 1024;
  localparam int GLOBAL_DEPTH_DEF = 256;
  localparam int PROG_DEPTH_DEF   = 65536;
  localparam int GCOUNT_W         = 9;

  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_PUSHC = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_MUL   = 8'd4;
  localparam logic [7:0] OP_DIV   = 8'd5;
  localparam logic [7:0] OP_MOD   = 8'd6;
  localparam logic [7:0] OP_RDINT = 8'd7;
  localparam logic [7:0] OP_WRINT = 8'd8;
  localparam logic [7:0] OP_RDCHR = 8'd9;
  localparam logic [7:0] OP_WRCHR = 8'd10;
  localparam logic [7:0] OP_PUSHG = 8'd11;
  localparam logic [7:0] OP_POPG  = 8'd12;
  localparam logic [7:0] OP_ASF   = 8'd13;
  localparam logic [7:0] OP_RSF   = 8'd14;
  localparam logic [7:0] OP_PUSHL = 8'd15;
  localparam logic [7:0] OP_POPL  = 8'd16;
  localparam logic [7:0] OP_EQ    = 8'd17;
  localparam logic [7:0] OP_NE    = 8'd18;
  localparam logic [7:0] OP_LT    = 8'd19;
  localparam logic [7:0] OP_LE    = 8'd20;
  localparam logic [7:0] OP_GT    = 8'd21;
  localparam logic [7:0] OP_GE    = 8'd22;
  localparam logic [7:0] OP_JMP   = 8'd23;
  localparam logic [7:0] OP_BRF   = 8'd24;
  localparam logic [7:0] OP_BRT   = 8'd25;
  localparam logic [7:0] OP_CALL  = 8'd26;
  localparam logic [7:0] OP_RET   = 8'd27;
  localparam logic [7:0] OP_DROP  = 8'd28;
  localparam logic [7:0] OP_PUSHR = 8'd29;
  localparam logic [7:0] OP_POPR  = 8'd30;
  localparam logic [7:0] OP_DUP   = 8'd31;

  localparam logic [3:0] ERR_NONE  = 4'd0;
  localparam logic [3:0] ERR_OVF   = 4'd1;
  localparam logic [3:0] ERR_UNF   = 4'd2;
  localparam logic [3:0] ERR_TAG   = 4'd3;
  localparam logic [3:0] ERR_DIVZ  = 4'd4;
  localparam logic [3:0] ERR_MODZ  = 4'd5;
  localparam logic [3:0] ERR_GIDX  = 4'd6;
  localparam logic [3:0] ERR_LADDR = 4'd7;
  localparam logic [3:0] ERR_RVE   = 4'd8;
  localparam logic [3:0] ERR_PC    = 4'd9;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_CHR  = 2'd2;

  typedef struct packed {
    logic [7:0]         op;
    logic signed [31:0] imm;
    logic [31:0]        inval;
    logic               binary;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RA, S_RB, S_EX, S_GO, S_DIV, S_CLR
  } state_t;

endpackage

// File: sv/svm_front.sv
// ----------------------------------------------------------------------------
// svm_front
// accepts instruction beats, decodes them and queues them for execution
// ----------------------------------------------------------------------------
module svm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,   // instr_word, in_value
  output logic          q_valid,
  input  logic          q_pop,
  output svm_pkg::item_t q_item
);
  import svm_pkg::*;

  item_t      q [2];
  logic       wptr, rptr;
  logic [1:0] count;
  item_t      dec;
  logic       push;

  always_comb begin
    dec.op     = s_tdata[31:24];
    dec.imm    = {{8{s_tdata[23]}}, s_tdata[23:0]};
    dec.inval  = s_tdata[63:32];
    dec.binary = dec.op inside {[OP_ADD:OP_MOD], [OP_EQ:OP_GE]};
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: sv/svm_div.sv
// ----------------------------------------------------------------------------
// svm_div
// iterative signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module svm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  import svm_pkg::*;

  logic [32:0] r;
  logic [31:0] q;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        busy, nq, nr;
  logic [32:0] r_sh;

  assign r_sh = {r[31:0], q[31]};

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= '0;
      q   <= dividend[31] ? 32'(-dividend) : dividend;
      d   <= divisor[31] ? 32'(-divisor) : divisor;
      nq  <= dividend[31] ^ divisor[31];
      nr  <= dividend[31];
    end else if (busy) begin
      if (r_sh >= {1'b0, d}) begin
        r <= r_sh - {1'b0, d};
        q <= {q[30:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = nq ? 32'(-q) : q;
  assign rem = nr ? 32'(-r[31:0]) : r[31:0];

endmodule

// File: sv/svm_back.sv
// ----------------------------------------------------------------------------
// svm_back
// sequencer that reads the stack, checks and executes one instruction
// ----------------------------------------------------------------------------
module svm_back #(
  parameter int STACK_DEPTH  = svm_pkg::STACK_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = svm_pkg::GLOBAL_DEPTH_DEF,
  parameter int PROG_DEPTH   = svm_pkg::PROG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [svm_pkg::GCOUNT_W-1:0]  cfg_wdata,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  svm_pkg::item_t                q_item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [55:0]                   m_tdata,
  output logic [1:0]                    m_tuser
);
  import svm_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int GW  = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam int PCW = $clog2(PROG_DEPTH);
  localparam logic signed [33:0] DEPTH_S = 34'(STACK_DEPTH);
  localparam logic signed [33:0] GDEP_S  = 34'(GLOBAL_DEPTH);
  localparam logic signed [33:0] PROG_S  = 34'(PROG_DEPTH);

  state_t state, state_next;

  logic [32:0]    smem [STACK_DEPTH];
  logic [31:0]    gmem [GLOBAL_DEPTH];
  logic           gval [GLOBAL_DEPTH];

  logic [SPW-1:0] sp;
  logic [31:0]    fp;
  logic [PCW-1:0] pc;
  logic [31:0]    rv;
  logic           rv_ok, halt;
  logic [3:0]     fault;
  logic [GCOUNT_W-1:0] gcount;
  item_t          cur;
  logic [32:0]    ta, tb, rd_data;
  logic [AW-1:0]  rd_addr;
  logic [31:0]    gdata;
  logic           gdata_ok;
  logic           div_have, div_start, div_done;
  logic [31:0]    dquo, drem;
  logic [SPW-1:0] clr_cnt;

  logic signed [33:0] spx, fpx, immx, pcx, gbx, gcx, npc, la;
  logic [3:0]     err, nr1, nr2, room1;
  logic           active, ok, out_free, commit, div_need;
  logic [31:0]    x, y, r;
  logic [31:0]    mul_lo;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [32:0]    wdata;

  // ---- state and decode helpers
  assign spx  = $signed({{(34-SPW){1'b0}}, sp});
  assign fpx  = {{2{fp[31]}}, fp};
  assign immx = {{2{cur.imm[31]}}, cur.imm};
  assign pcx  = $signed({{(34-PCW){1'b0}}, pc});
  assign gcx  = $signed({{(34-GCOUNT_W){1'b0}}, gcount});
  assign gbx  = (gcx < GDEP_S) ? gcx : GDEP_S;
  assign la   = fpx + immx;
  assign active   = !halt && (fault == ERR_NONE);
  assign out_free = !m_tvalid || m_tready;
  assign x = tb[31:0];
  assign y = ta[31:0];
  assign mul_lo = x * y;

  assign nr1   = (spx < 34'sd1) ? ERR_UNF : (!ta[32] ? ERR_TAG : ERR_NONE);
  assign nr2   = (nr1 != ERR_NONE) ? nr1 :
                 (spx < 34'sd2) ? ERR_UNF : (!tb[32] ? ERR_TAG : ERR_NONE);
  assign room1 = (spx + 34'sd1 > DEPTH_S) ? ERR_OVF : ERR_NONE;

  // ---- instruction checks and next pc
  always_comb begin
    logic [3:0] e;
    e   = ERR_NONE;
    npc = pcx + 34'sd1;
    case (cur.op)
      OP_HALT: npc = pcx;
      OP_PUSHC, OP_RDINT, OP_RDCHR: e = room1;
      OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: e = nr2;
      OP_DIV, OP_MOD: begin
        e = nr2;
        if (e == ERR_NONE && y == 32'd0) e = (cur.op == OP_DIV) ? ERR_DIVZ : ERR_MODZ;
      end
      OP_WRINT, OP_WRCHR, OP_POPR: e = nr1;
      OP_PUSHG: e = (immx < 34'sd0 || immx >= gbx) ? ERR_GIDX : room1;
      OP_POPG:  e = (immx < 34'sd0 || immx >= gbx) ? ERR_GIDX : nr1;
      OP_ASF: begin
        if (spx >= DEPTH_S) e = ERR_OVF;
        else if (immx < 34'sd0) e = ERR_UNF;
        else if (spx + 34'sd1 + immx > DEPTH_S) e = ERR_OVF;
      end
      OP_RSF: begin
        if (fpx <= 34'sd0) e = ERR_UNF;
        else if (fpx > DEPTH_S) e = ERR_OVF;
        else if (ta[32]) e = ERR_TAG;
      end
      OP_PUSHL: e = (la < 34'sd0 || la >= spx) ? ERR_LADDR : room1;
      OP_POPL:  e = (la < 34'sd0 || la >= spx) ? ERR_LADDR : ERR_NONE;
      OP_JMP:   npc = immx;
      OP_BRF, OP_BRT: begin
        e = nr1;
        if ((y != 32'd0) == (cur.op == OP_BRT)) npc = immx;
      end
      OP_CALL: begin
        npc = immx;
        e   = room1;
      end
      OP_RET: begin
        if (spx < 34'sd1) e = ERR_UNF;
        else if (ta[32]) e = ERR_TAG;
        npc = {{2{y[31]}}, y};
      end
      OP_DROP: begin
        if (spx - immx < 34'sd0) e = ERR_UNF;
        else if (spx - immx > DEPTH_S) e = ERR_OVF;
      end
      OP_PUSHR: e = !rv_ok ? ERR_RVE : room1;
      OP_DUP:   e = (nr1 != ERR_NONE) ? nr1 : room1;
      default: ;
    endcase
    if (e == ERR_NONE && (npc < 34'sd0 || npc >= PROG_S)) e = ERR_PC;
    err = e;
  end

  assign ok       = active && (err == ERR_NONE);
  assign div_need = ok && (cur.op == OP_DIV || cur.op == OP_MOD) && !div_have;

  always_comb begin
    case (cur.op)
      OP_ADD:  r = x + y;
      OP_SUB:  r = x - y;
      OP_MUL:  r = mul_lo;
      OP_DIV:  r = dquo;
      OP_MOD:  r = drem;
      OP_EQ:   r = {31'd0, $signed(x) == $signed(y)};
      OP_NE:   r = {31'd0, $signed(x) != $signed(y)};
      OP_LT:   r = {31'd0, $signed(x) <  $signed(y)};
      OP_LE:   r = {31'd0, $signed(x) <= $signed(y)};
      OP_GT:   r = {31'd0, $signed(x) >  $signed(y)};
      default: r = {31'd0, $signed(x) >= $signed(y)};
    endcase
  end

  // ---- sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_RA;
      S_RA:   state_next = S_RB;
      S_RB:   state_next = S_EX;
      S_EX:   state_next = S_GO;
      S_GO: begin
        if (div_need) state_next = S_DIV;
        else if (out_free) begin
          if (ok && cur.op == OP_ASF && cur.imm != 32'sd0) state_next = S_CLR;
          else state_next = S_IDLE;
        end
      end
      S_DIV:  if (div_done) state_next = S_GO;
      S_CLR:  if (clr_cnt == SPW'(1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    logic signed [33:0] a;
    q_pop     = (state == S_IDLE) && q_valid;
    div_start = (state == S_GO) && div_need;
    commit    = (state == S_GO) && !div_need && out_free;
    a = spx - 34'sd1;
    case (state)
      S_RA: begin
        if (cur.op == OP_RSF) a = fpx - 34'sd1;
        else if (cur.op == OP_PUSHL) a = la;
      end
      S_RB: a = spx - 34'sd2;
      default: ;
    endcase
    rd_addr = a[AW-1:0];
  end

  // ---- stack write port
  always_comb begin
    logic signed [33:0] wa;
    logic signed [33:0] pc1;
    pc1   = pcx + 34'sd1;
    we    = 1'b0;
    wa    = spx;
    wdata = '0;
    if (state == S_CLR) begin
      we = 1'b1;
    end else if (commit && ok) begin
      case (cur.op)
        OP_PUSHC:         begin we = 1'b1; wdata = {1'b1, cur.imm}; end
        OP_RDINT, OP_RDCHR: begin we = 1'b1; wdata = {1'b1, cur.inval}; end
        OP_PUSHG: begin
          we = 1'b1;
          wdata = {1'b1, gdata_ok ? gdata : 32'd0};
        end
        OP_ASF:   begin we = 1'b1; wdata = {1'b0, fp}; end
        OP_PUSHL, OP_DUP: begin we = 1'b1; wdata = ta; end
        OP_POPL:  begin we = 1'b1; wa = la; wdata = ta; end
        OP_CALL:  begin we = 1'b1; wdata = {1'b0, pc1[31:0]}; end
        OP_PUSHR: begin we = 1'b1; wdata = {1'b1, rv}; end
        default: begin
          if (cur.binary) begin
            we = 1'b1;
            wa = spx - 34'sd2;
            wdata = {1'b1, r};
          end
        end
      endcase
    end
    waddr = wa[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) smem[waddr] <= wdata;
    rd_data <= smem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (commit && ok && cur.op == OP_POPG) gmem[cur.imm[GW-1:0]] <= y;
    gdata <= gmem[cur.imm[GW-1:0]];
  end

  // global slots read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GLOBAL_DEPTH; i++) gval[i] <= 1'b0;
      gdata_ok <= 1'b0;
    end else begin
      if (commit && ok && cur.op == OP_POPG) gval[cur.imm[GW-1:0]] <= 1'b1;
      gdata_ok <= gval[cur.imm[GW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    if (state == S_RB) ta <= rd_data;
    if (state == S_EX) tb <= rd_data;
  end

  // ---- architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sp       <= '0;
      fp       <= '0;
      pc       <= '0;
      rv       <= '0;
      rv_ok    <= 1'b0;
      halt     <= 1'b0;
      fault    <= ERR_NONE;
      gcount   <= '0;
      div_have <= 1'b0;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) gcount <= cfg_wdata;
      if (m_tready && !commit) m_tvalid <= 1'b0;
      if (state == S_IDLE) div_have <= 1'b0;
      if (state == S_DIV && div_done) div_have <= 1'b1;
      if (state == S_CLR) begin
        sp      <= sp + SPW'(1);
        clr_cnt <= clr_cnt - SPW'(1);
      end
      if (commit) begin
        logic           h;
        logic [3:0]     f;
        logic [PCW-1:0] p;
        logic [1:0]     k;
        logic [31:0]    ov;
        h = halt;
        f = fault;
        p = pc;
        k = KIND_NONE;
        ov = 32'd0;
        if (active && err != ERR_NONE) f = err;
        if (ok) begin
          p = npc[PCW-1:0];
          case (cur.op)
            OP_HALT: h = 1'b1;
            OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHG, OP_PUSHL, OP_CALL, OP_PUSHR, OP_DUP:
              sp <= sp + SPW'(1);
            OP_WRINT, OP_WRCHR: begin
              k  = (cur.op == OP_WRINT) ? KIND_INT : KIND_CHR;
              ov = y;
              sp <= sp - SPW'(1);
            end
            OP_POPG, OP_POPL, OP_BRF, OP_BRT, OP_RET: sp <= sp - SPW'(1);
            OP_ASF: begin
              // new frame starts just above the saved fp
              fp      <= 32'(sp + SPW'(1));
              sp      <= sp + SPW'(1);
              clr_cnt <= cur.imm[SPW-1:0];
            end
            OP_RSF: begin
              sp <= fp[SPW-1:0] - SPW'(1);
              fp <= y;
            end
            OP_DROP: sp <= sp - cur.imm[SPW-1:0];
            OP_POPR: begin
              rv    <= y;
              rv_ok <= 1'b1;
              sp    <= sp - SPW'(1);
            end
            default: if (cur.binary) sp <= sp - SPW'(1);
          endcase
        end
        halt     <= h;
        fault    <= f;
        pc       <= p;
        m_tvalid <= 1'b1;
        m_tuser  <= k;
        m_tdata  <= {3'd0, f, h || (f != ERR_NONE), ov, 16'(p)};
      end
    end
  end

  svm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x),
    .divisor  (y),
    .done     (div_done),
    .quo      (dquo),
    .rem      (drem)
  );

  // ---- checks
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt) else $error("halt flag cleared");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (fault != ERR_NONE) |=> (fault == $past(fault)))
    else $error("fault code changed once set");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(sp) <= 32'(STACK_DEPTH))) else $error("stack pointer beyond depth");

  a_div_when_ok: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (ok && y != 32'd0)) else $error("divider started on a bad operand");

endmodule

// File: sv/stack_vm_execute_unit_core.sv
// ----------------------------------------------------------------------------
// stack_vm_execute_unit_core
// stack machine execute unit: one instruction word in, one status beat out
// ----------------------------------------------------------------------------
// Each input beat is executed against the tagged operand stack, the global
// slots and the return-value register; exactly one output beat reports the
// next pc, any console output and the sticky run status. In the sequencer an
// instruction passes S_IDLE, where it leaves the queue, S_RA and S_RB, which
// issue the two registered stack reads, S_EX and S_GO, where it is checked and
// committed; div and mod wait in S_DIV for the bit-serial divider and return to
// S_GO to commit, and asf then clears its slots one by one in S_CLR through the
// single stack write port. A two-beat queue in front lets the next instruction
// be taken while one runs, and the output register holds a result until it is taken.
module stack_vm_execute_unit_core #(
  parameter int STACK_DEPTH  = svm_pkg::STACK_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = svm_pkg::GLOBAL_DEPTH_DEF,
  parameter int PROG_DEPTH   = svm_pkg::PROG_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [svm_pkg::GCOUNT_W-1:0] cfg_wdata,   // global_count
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [63:0]                  s_tdata,     // instr_word, in_value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [55:0]                  m_tdata,     // next_pc, out_value, stopped, error_code
  output logic [1:0]                   m_tuser      // out_kind
);
  import svm_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  svm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  svm_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .GLOBAL_DEPTH (GLOBAL_DEPTH),
    .PROG_DEPTH   (PROG_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
